[rtl/core/tcprx_pkg.sv]
// ----------------------------------------------------------------------------
// tcprx_pkg: shared definitions for the TCP receive state tracker
// State codes, flag masks, register indexes and the result record layout.
// ----------------------------------------------------------------------------
package tcprx_pkg;

  // Connection state codes
  localparam logic [3:0] ST_CLOSED     = 4'd0;
  localparam logic [3:0] ST_SYN_SENT   = 4'd1;
  localparam logic [3:0] ST_ESTAB      = 4'd2;
  localparam logic [3:0] ST_FIN_WAIT1  = 4'd3;
  localparam logic [3:0] ST_FIN_WAIT2  = 4'd4;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'd5;
  localparam logic [3:0] ST_CLOSING    = 4'd6;
  localparam logic [3:0] ST_LAST_ACK   = 4'd7;
  localparam logic [3:0] ST_TIME_WAIT  = 4'd8;

  // TCP header flag masks
  localparam logic [7:0] FLAG_FIN    = 8'h01;
  localparam logic [7:0] FLAG_RST    = 8'h04;
  localparam logic [7:0] FLAG_ACK    = 8'h10;
  localparam logic [7:0] FLAG_SYNACK = 8'h12;

  // Wake request codes
  localparam logic [1:0] WAKE_NONE = 2'd0;
  localparam logic [1:0] WAKE_ONE  = 2'd1;
  localparam logic [1:0] WAKE_ALL  = 2'd2;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_START_STATE     = 2'd0;
  localparam logic [1:0] REG_START_SEND_NEXT = 2'd1;
  localparam logic [1:0] REG_START_RECV_NEXT = 2'd2;

  localparam logic [3:0]  RST_START_STATE = ST_SYN_SENT;
  localparam int unsigned OUT_DATA_W      = 112;
  localparam int unsigned IN_DATA_W       = 112;

  // One result item, field order from the highest bit down
  typedef struct packed {
    logic [31:0] recv_next;
    logic [15:0] send_window;
    logic [31:0] send_unacked;
    logic        connect_error;
    logic        fin_seen;
    logic        reset_seen;
    logic        unregister;
    logic [1:0]  wake_kind;
    logic [15:0] bytes_stored;
    logic [1:0]  ack_count;
    logic [3:0]  conn_state;
  } result_t;

endpackage

[rtl/core/tcp_receive_state_tracker_top.sv]
// ----------------------------------------------------------------------------
// tcp_receive_state_tracker_top: receive-side state tracker for one connection
// Takes one parsed TCP segment per transfer, updates the connection state and
// sequence registers, and returns one result per segment.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake                Payload
//  s_axis    in    tvalid/tready            tdata: seq, ack, window, len, free;
//                                           tuser: segment flags
//  m_axis    out   tvalid/tready            tdata: one result record
//  apb       in    psel/penable/pwrite      3 registers at 0x0, 0x4, 0x8
//
//  Each segment passes the input register, then is evaluated and lands in
//  the result register. A new segment is taken every cycle when not stalled;
//  the state is updated in the edge that loads the result, unless a config
//  write takes it, so the next segment sees the previous one's effect.
//  Reset loads the start registers' reset values into the state at once.
//  A stalled m_axis holds the result and backs up into the input register;
//  s_axis tready drops only when both stages are full and the sink stalls.
//
module tcp_receive_state_tracker_top
  import tcprx_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // segment input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] seq_number, [63:32] ack_number, [79:64] window,
  // [95:80] payload_len, [111:96] ring_free
  input  logic [111:0] s_axis_tdata,
  // [7:0] seg_flags
  input  logic [7:0]   s_axis_tuser,
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] conn_state, [5:4] ack_count, [21:6] bytes_stored, [23:22] wake_kind,
  // [24] unregister, [25] reset_seen, [26] fin_seen, [27] connect_error,
  // [59:28] send_unacked, [75:60] send_window, [107:76] recv_next, [111:108] 0
  output logic [111:0] m_axis_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [3:0]  start_state_q;
  logic [31:0] start_send_next_q;
  logic [31:0] start_recv_next_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q     <= RST_START_STATE;
      start_send_next_q <= '0;
      start_recv_next_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_STATE:     start_state_q     <= pwdata[3:0];
        REG_START_SEND_NEXT: start_send_next_q <= pwdata;
        REG_START_RECV_NEXT: start_recv_next_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_STATE:     prdata = {28'd0, start_state_q};
      REG_START_SEND_NEXT: prdata = start_send_next_q;
      REG_START_RECV_NEXT: prdata = start_recv_next_q;
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic        in_valid_q;
  logic [7:0]  flags_q;
  logic [31:0] seq_q;
  logic [31:0] ackn_q;
  logic [15:0] wnd_q;
  logic [15:0] plen_q;
  logic [15:0] free_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_xfer;

  // Evaluate the held segment whenever the result register can take it
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      flags_q <= s_axis_tuser;
      seq_q   <= s_axis_tdata[31:0];
      ackn_q  <= s_axis_tdata[63:32];
      wnd_q   <= s_axis_tdata[79:64];
      plen_q  <= s_axis_tdata[95:80];
      free_q  <= s_axis_tdata[111:96];
    end
  end

  // --------------------------------------------------------------------------
  // Connection state
  // --------------------------------------------------------------------------
  logic [3:0]  state_q,    state_d;
  logic [31:0] snd_nxt_q,  snd_nxt_d;
  logic [31:0] snd_una_q,  snd_una_d;
  logic [31:0] rcv_nxt_q,  rcv_nxt_d;
  logic [15:0] snd_wnd_q,  snd_wnd_d;
  logic        rst_flag_q, rst_flag_d;
  logic        fin_flag_q, fin_flag_d;
  logic        err_flag_q, err_flag_d;
  logic [1:0]  acks;
  logic [15:0] stored;
  logic [1:0]  wake;
  logic        unreg;

  logic        is_synack;
  logic        is_rst;
  logic        ack_hit;
  logic [31:0] ack_diff;
  logic        data_ok;
  logic [31:0] rcv_after_data;
  logic [31:0] fin_seq;
  logic        fin_ok;
  logic [3:0]  state_after_ack;

  always_comb begin
    is_synack = (state_q == ST_SYN_SENT) && ((flags_q & FLAG_SYNACK) == FLAG_SYNACK);
    is_rst    = (flags_q & FLAG_RST) != 8'd0;
    ack_diff  = ackn_q - snd_una_q;
    ack_hit   = ackn_q == snd_nxt_q;

    // ACK step: the state change feeds the FIN step below
    state_after_ack = state_q;
    if ((flags_q & FLAG_ACK) != 8'd0 && ack_hit) begin
      if (state_q == ST_FIN_WAIT1) begin
        state_after_ack = ST_FIN_WAIT2;
      end else if (state_q == ST_LAST_ACK) begin
        state_after_ack = ST_CLOSED;
      end
    end

    // In-order data: store what fits, advance only by that much
    data_ok        = (plen_q != 16'd0) && (seq_q == rcv_nxt_q);
    stored         = '0;
    if (data_ok) begin
      stored = (plen_q < free_q) ? plen_q : free_q;
    end
    rcv_after_data = data_ok ? (seq_q + {16'd0, stored}) : rcv_nxt_q;

    fin_seq = seq_q + {16'd0, plen_q};
    fin_ok  = ((flags_q & FLAG_FIN) != 8'd0) && (fin_seq == rcv_after_data);

    state_d    = state_q;
    snd_nxt_d  = snd_nxt_q;
    snd_una_d  = snd_una_q;
    rcv_nxt_d  = rcv_nxt_q;
    snd_wnd_d  = snd_wnd_q;
    rst_flag_d = rst_flag_q;
    fin_flag_d = fin_flag_q;
    err_flag_d = err_flag_q;
    acks       = 2'd0;
    wake       = WAKE_NONE;
    unreg      = 1'b0;

    if (is_synack) begin
      // Connect completes; nothing else in the segment counts
      rcv_nxt_d  = seq_q + 32'd1;
      snd_nxt_d  = snd_nxt_q + 32'd1;
      snd_una_d  = snd_nxt_q + 32'd1;
      snd_wnd_d  = wnd_q;
      state_d    = ST_ESTAB;
      err_flag_d = 1'b0;
      acks       = 2'd1;
      wake       = WAKE_ONE;
      stored     = '0;
    end else if (is_rst) begin
      state_d    = ST_CLOSED;
      rst_flag_d = 1'b1;
      err_flag_d = 1'b1;
      wake       = WAKE_ALL;
      stored     = '0;
    end else begin
      if ((flags_q & FLAG_ACK) != 8'd0) begin
        // Serial compare: advance when the distance is in 1 .. 2^31-1
        if (ack_diff != 32'd0 && !ack_diff[31]) begin
          snd_una_d = ackn_q;
        end
        snd_wnd_d = wnd_q;
        unreg     = (state_q == ST_LAST_ACK) && ack_hit;
      end
      state_d   = state_after_ack;
      rcv_nxt_d = rcv_after_data;
      if (data_ok) begin
        acks = 2'd1;
        wake = WAKE_ONE;
      end
      if (fin_ok) begin
        fin_flag_d = 1'b1;
        rcv_nxt_d  = rcv_after_data + 32'd1;
        wake       = WAKE_ALL;
        case (state_after_ack)
          ST_ESTAB:     state_d = ST_CLOSE_WAIT;
          ST_FIN_WAIT1: state_d = ST_CLOSING;
          ST_FIN_WAIT2: state_d = ST_TIME_WAIT;
          default:      state_d = state_after_ack;
        endcase
        if (state_after_ack == ST_ESTAB || state_after_ack == ST_FIN_WAIT1 ||
            state_after_ack == ST_FIN_WAIT2) begin
          acks = acks + 2'd1;
        end
      end
    end
  end

  // Config writes load the matching state; write only when idle (unenforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= RST_START_STATE;
      snd_nxt_q  <= '0;
      snd_una_q  <= '0;
      rcv_nxt_q  <= '0;
      snd_wnd_q  <= '0;
      rst_flag_q <= 1'b0;
      fin_flag_q <= 1'b0;
      err_flag_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_STATE: state_q <= pwdata[3:0];
        REG_START_SEND_NEXT: begin
          snd_nxt_q <= pwdata;
          snd_una_q <= pwdata;
        end
        REG_START_RECV_NEXT: rcv_nxt_q <= pwdata;
        default: ;
      endcase
    end else if (advance) begin
      state_q    <= state_d;
      snd_nxt_q  <= snd_nxt_d;
      snd_una_q  <= snd_una_d;
      rcv_nxt_q  <= rcv_nxt_d;
      snd_wnd_q  <= snd_wnd_d;
      rst_flag_q <= rst_flag_d;
      fin_flag_q <= fin_flag_d;
      err_flag_q <= err_flag_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  result_t res_d;
  result_t res_q;

  always_comb begin
    res_d.conn_state    = state_d;
    res_d.ack_count     = acks;
    res_d.bytes_stored  = stored;
    res_d.wake_kind     = wake;
    res_d.unregister    = unreg;
    res_d.reset_seen    = rst_flag_d;
    res_d.fin_seen      = fin_flag_d;
    res_d.connect_error = err_flag_d;
    res_d.send_unacked  = snd_una_d;
    res_d.send_window   = snd_wnd_d;
    res_d.recv_next     = rcv_nxt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ack_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_q.ack_count != 2'd3)
    else $error("ack_count out of range");

  a_store_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.bytes_stored != 16'd0) |-> res_q.ack_count != 2'd0)
    else $error("stored data without an ACK");

  a_unreg_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.unregister) |-> res_q.conn_state == ST_CLOSED)
    else $error("unregister while not closed");

  a_reset_wakes_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_rst && !is_synack) |=> res_q.wake_kind == WAKE_ALL)
    else $error("RST without wake-all");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

endmodule
